// ===== design/sdf_pkg.sv =====
// Shared types, constants and helpers for the spring-damper force pipeline.
`timescale 1ns / 1ps
package sdf_pkg;

	localparam int SQRT_STEPS = 32;
	localparam int DIV_STEPS  = 31;

	typedef enum logic [1:0] {
		KIND_RADIAL = 2'd0,
		KIND_WALL   = 2'd1,
		KIND_CIRCUM = 2'd2,
		KIND_TRANSV = 2'd3
	} kind_t;

	typedef enum logic [3:0] {
		REG_K_RADIAL = 4'd0,
		REG_C_RADIAL = 4'd1,
		REG_K_WALL   = 4'd2,
		REG_C_WALL   = 4'd3,
		REG_K_CIRCUM = 4'd4,
		REG_C_CIRCUM = 4'd5,
		REG_K_TRANSV = 4'd6,
		REG_C_TRANSV = 4'd7
	} reg_idx_t;

	localparam logic signed [47:0] MAX48 = 48'sh7FFF_FFFF_FFFF;
	localparam logic signed [47:0] MIN48 = 48'sh8000_0000_0000;

	// item fields carried through the square-root pipe
	typedef struct packed {
		logic [2:0][31:0] dmag;
		logic [2:0]       dneg;
		logic [2:0][31:0] rv;
		logic [30:0]      rest;
		logic             acc_en;
		logic             start;
		logic [31:0]      kg;
		logic [31:0]      cg;
	} side_t;

	// item fields carried through the divider pipe
	typedef struct packed {
		logic [2:0]       dneg;
		logic [2:0][31:0] rv;
		logic [30:0]      rest;
		logic             acc_en;
		logic             start;
		logic [31:0]      kg;
		logic [31:0]      cg;
		logic [31:0]      len;
		logic             degen;
	} dside_t;

	typedef struct packed {
		logic [2:0][47:0] force_v;
		logic [2:0][47:0] wheel_v;
		logic             degen;
	} result_t;

	function automatic logic signed [47:0] sat48(input logic signed [59:0] x);
		if (x[59:47] == '0 || x[59:47] == '1)
			return x[47:0];
		else if (x[59])
			return MIN48;
		else
			return MAX48;
	endfunction

endpackage

// ===== design/spring_damper_force_top.sv =====
// Top level of the spring-damper force pipeline: ports, gain registers, front stages.
`timescale 1ns / 1ps
// Usage:
//  Input channel (in_valid/in_ready) takes one spring per cycle while in_ready is
//  high: relative position and velocity of its nodes, rest length, kind and a
//  start flag that clears the wheel force accumulator before the spring is applied.
//  Output channel (out_valid/out_ready) gives one result per spring, in order:
//  force vector on the second node, accumulator after the spring, and a
//  degenerate flag for zero length.
//  Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data) writes the eight
//  Q24.8 gains; cfg_ready is always high, indices above 7 are ignored.
//  Gains are sampled when a spring enters, so write them only while idle.
//  The pipeline has 2 front stages, 32 square-root stages (one root bit each),
//  31 divider stages (one direction bit each) and 7 force stages.
//  Throughput is one spring per cycle while the receiver does not stall.
//  When the receiver stalls with a result held, the whole pipeline holds and
//  in_ready drops; nothing is lost or repeated.
//  Reset clears gains, accumulator and all valid bits.
module spring_damper_force_top
	import sdf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [3:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic signed [31:0] delta_x,
	input  logic signed [31:0] delta_y,
	input  logic signed [31:0] delta_z,
	input  logic signed [31:0] rel_vel_x,
	input  logic signed [31:0] rel_vel_y,
	input  logic signed [31:0] rel_vel_z,
	input  logic [30:0] rest_length,
	input  logic [1:0]  spring_kind,
	input  logic        start_pass,
	output logic        out_valid,
	input  logic        out_ready,
	output logic signed [47:0] force_x,
	output logic signed [47:0] force_y,
	output logic signed [47:0] force_z,
	output logic signed [47:0] wheel_force_x,
	output logic signed [47:0] wheel_force_y,
	output logic signed [47:0] wheel_force_z,
	output logic        degenerate
);

	logic [31:0] k_radial_q, c_radial_q, k_wall_q, c_wall_q;
	logic [31:0] k_circum_q, c_circum_q, k_transv_q, c_transv_q;

	logic en;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_radial_q <= '0;
			c_radial_q <= '0;
			k_wall_q   <= '0;
			c_wall_q   <= '0;
			k_circum_q <= '0;
			c_circum_q <= '0;
			k_transv_q <= '0;
			c_transv_q <= '0;
		end else if (cfg_valid) begin
			case (reg_idx_t'(cfg_index))
				REG_K_RADIAL: k_radial_q <= cfg_data;
				REG_C_RADIAL: c_radial_q <= cfg_data;
				REG_K_WALL:   k_wall_q   <= cfg_data;
				REG_C_WALL:   c_wall_q   <= cfg_data;
				REG_K_CIRCUM: k_circum_q <= cfg_data;
				REG_C_CIRCUM: c_circum_q <= cfg_data;
				REG_K_TRANSV: k_transv_q <= cfg_data;
				REG_C_TRANSV: c_transv_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// stage 1: magnitudes, squares, gain select
	logic [2:0][31:0] dl_c, dm_c;
	logic [2:0][63:0] sq_c;
	side_t            side_c;

	always_comb begin
		dl_c = {delta_z, delta_y, delta_x};
		for (int i = 0; i < 3; i++) begin
			dm_c[i] = dl_c[i][31] ? (~dl_c[i] + 32'd1) : dl_c[i];
			sq_c[i] = 64'(dm_c[i]) * 64'(dm_c[i]);
		end
		side_c.dmag   = dm_c;
		side_c.dneg   = {delta_z[31], delta_y[31], delta_x[31]};
		side_c.rv     = {rel_vel_z, rel_vel_y, rel_vel_x};
		side_c.rest   = rest_length;
		side_c.start  = start_pass;
		side_c.acc_en = 1'b0;
		side_c.kg     = k_transv_q;
		side_c.cg     = c_transv_q;
		case (kind_t'(spring_kind))
			KIND_RADIAL: begin
				side_c.kg     = k_radial_q;
				side_c.cg     = c_radial_q;
				side_c.acc_en = 1'b1;
			end
			KIND_WALL: begin
				side_c.kg     = k_wall_q;
				side_c.cg     = c_wall_q;
				side_c.acc_en = 1'b1;
			end
			KIND_CIRCUM: begin
				side_c.kg = k_circum_q;
				side_c.cg = c_circum_q;
			end
			default: ;
		endcase
	end

	logic             v_s1, v_s2;
	logic [2:0][63:0] sq_s1;
	side_t            side_s1, side_s2;
	logic [63:0]      n_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sq_s1   <= sq_c;
			side_s1 <= side_c;
			n_s2    <= sq_s1[0] + sq_s1[1] + sq_s1[2];
			side_s2 <= side_s1;
		end
	end

	logic             sq_v;
	logic [31:0]      sq_len;
	side_t            sq_side;
	logic             dv_v;
	logic [2:0][30:0] dv_q;
	dside_t           dv_side;
	result_t          res;

	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	sdf_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_v     (v_s2),
		.in_n     (n_s2),
		.in_side  (side_s2),
		.out_v    (sq_v),
		.out_len  (sq_len),
		.out_side (sq_side)
	);

	sdf_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_v     (sq_v),
		.in_len   (sq_len),
		.in_side  (sq_side),
		.out_v    (dv_v),
		.out_q    (dv_q),
		.out_side (dv_side)
	);

	sdf_force u_force (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_v    (dv_v),
		.in_q    (dv_q),
		.in_side (dv_side),
		.out_v   (out_valid),
		.out_res (res)
	);

	assign force_x       = res.force_v[0];
	assign force_y       = res.force_v[1];
	assign force_z       = res.force_v[2];
	assign wheel_force_x = res.wheel_v[0];
	assign wheel_force_y = res.wheel_v[1];
	assign wheel_force_z = res.wheel_v[2];
	assign degenerate    = res.degen;

endmodule

// ===== design/sdf_sqrt.sv =====
// Pipelined integer square root, one result bit per stage.
`timescale 1ns / 1ps
module sdf_sqrt
	import sdf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        in_v,
	input  logic [63:0] in_n,
	input  side_t       in_side,
	output logic        out_v,
	output logic [31:0] out_len,
	output side_t       out_side
);

	logic [63:0] n_s    [0:SQRT_STEPS-1];
	logic [63:0] r_s    [0:SQRT_STEPS-1];
	side_t       side_s [0:SQRT_STEPS-1];
	logic        v_s    [0:SQRT_STEPS-1];

	for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_step
		localparam logic [63:0] BIT = 64'd1 << (62 - 2 * j);
		logic [63:0] n_in;
		logic [63:0] r_in;
		side_t       sd_in;
		logic        v_in;
		logic [64:0] trial;

		if (j == 0) begin : g_first
			assign n_in  = in_n;
			assign r_in  = '0;
			assign sd_in = in_side;
			assign v_in  = in_v;
		end else begin : g_next
			assign n_in  = n_s[j-1];
			assign r_in  = r_s[j-1];
			assign sd_in = side_s[j-1];
			assign v_in  = v_s[j-1];
		end

		assign trial = {1'b0, r_in} + {1'b0, BIT};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				v_s[j] <= 1'b0;
			else if (en)
				v_s[j] <= v_in;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if ({1'b0, n_in} >= trial) begin
					n_s[j] <= n_in - trial[63:0];
					r_s[j] <= (r_in >> 1) + BIT;
				end else begin
					n_s[j] <= n_in;
					r_s[j] <= r_in >> 1;
				end
				side_s[j] <= sd_in;
			end
		end
	end

	assign out_v    = v_s[SQRT_STEPS-1];
	assign out_len  = r_s[SQRT_STEPS-1][31:0];
	assign out_side = side_s[SQRT_STEPS-1];

endmodule

// ===== design/sdf_div.sv =====
// Pipelined three-lane restoring divider forming the unit direction.
`timescale 1ns / 1ps
module sdf_div
	import sdf_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_v,
	input  logic [31:0]      in_len,
	input  side_t            in_side,
	output logic             out_v,
	output logic [2:0][30:0] out_q,
	output dside_t           out_side
);

	dside_t           ds_in0;
	logic [2:0][61:0] rem_in0;

	logic [2:0][61:0] rem_s [0:DIV_STEPS-1];
	logic [2:0][30:0] q_s   [0:DIV_STEPS-1];
	dside_t           ds_s  [0:DIV_STEPS-1];
	logic             v_s   [0:DIV_STEPS-1];

	always_comb begin
		ds_in0.dneg   = in_side.dneg;
		ds_in0.rv     = in_side.rv;
		ds_in0.rest   = in_side.rest;
		ds_in0.acc_en = in_side.acc_en;
		ds_in0.start  = in_side.start;
		ds_in0.kg     = in_side.kg;
		ds_in0.cg     = in_side.cg;
		ds_in0.len    = in_len;
		ds_in0.degen  = (in_len == '0);
		for (int i = 0; i < 3; i++)
			rem_in0[i] = {in_side.dmag[i], 30'd0};
	end

	for (genvar j = 0; j < DIV_STEPS; j++) begin : g_step
		localparam int B = DIV_STEPS - 1 - j;
		logic [2:0][61:0] rem_in;
		logic [2:0][30:0] q_in;
		dside_t           sd_in;
		logic             v_in;
		logic [62:0]      dv;
		logic [2:0][61:0] rem_nx;
		logic [2:0][30:0] q_nx;

		if (j == 0) begin : g_first
			assign rem_in = rem_in0;
			assign q_in   = '0;
			assign sd_in  = ds_in0;
			assign v_in   = in_v;
		end else begin : g_next
			assign rem_in = rem_s[j-1];
			assign q_in   = q_s[j-1];
			assign sd_in  = ds_s[j-1];
			assign v_in   = v_s[j-1];
		end

		assign dv = {31'd0, sd_in.len} << B;

		always_comb begin
			for (int i = 0; i < 3; i++) begin
				rem_nx[i] = rem_in[i];
				q_nx[i]   = q_in[i];
				if ({1'b0, rem_in[i]} >= dv) begin
					rem_nx[i]  = rem_in[i] - dv[61:0];
					q_nx[i][B] = 1'b1;
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				v_s[j] <= 1'b0;
			else if (en)
				v_s[j] <= v_in;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j] <= rem_nx;
				q_s[j]   <= q_nx;
				ds_s[j]  <= sd_in;
			end
		end
	end

	assign out_v    = v_s[DIV_STEPS-1];
	assign out_q    = q_s[DIV_STEPS-1];
	assign out_side = ds_s[DIV_STEPS-1];

endmodule

// ===== design/sdf_force.sv =====
// Closing speed, scalar force, force vector and wheel force accumulator stages.
`timescale 1ns / 1ps
module sdf_force
	import sdf_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_v,
	input  logic [2:0][30:0] in_q,
	input  dside_t           in_side,
	output logic             out_v,
	output result_t          out_res
);

	// stage 1: direction, velocity products, spring term product
	logic                    v_s1;
	logic [2:0][63:0]        p_s1;
	logic [64:0]             fkp_s1;
	logic                    fkneg_s1;
	logic [2:0][30:0]        um_s1;
	logic [2:0]              uneg_s1;
	logic [31:0]             cg_s1;
	logic                    acc_s1, start_s1, degen_s1;

	logic [2:0][63:0] p_c;
	logic signed [31:0] u_c;
	logic signed [33:0] st_c;
	logic [32:0] smag_c;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			u_c    = in_side.dneg[i] ? -$signed({1'b0, in_q[i]}) : $signed({1'b0, in_q[i]});
			p_c[i] = $signed(in_side.rv[i]) * u_c;
		end
		st_c   = $signed({2'b00, in_side.len}) - $signed({3'b000, in_side.rest});
		smag_c = st_c[33] ? 33'(-st_c) : st_c[32:0];
	end

	// stage 2: dot product, speed
	logic             v_s2;
	logic [32:0]      spd_s2;
	logic             spdneg_s2;
	logic [56:0]      fk_s2;
	logic             fkneg_s2;
	logic [2:0][30:0] um_s2;
	logic [2:0]       uneg_s2;
	logic [31:0]      cg_s2;
	logic             acc_s2, start_s2, degen_s2;

	logic signed [63:0] dot_c;
	logic [63:0]        dabs_c;

	always_comb begin
		dot_c  = $signed(p_s1[0]) + $signed(p_s1[1]) + $signed(p_s1[2]);
		dabs_c = dot_c[63] ? 64'(-dot_c) : dot_c;
	end

	// stage 3: damper term product
	logic             v_s3;
	logic [64:0]      fcp_s3;
	logic             spdneg_s3;
	logic [56:0]      fk_s3;
	logic             fkneg_s3;
	logic [2:0][30:0] um_s3;
	logic [2:0]       uneg_s3;
	logic             acc_s3, start_s3, degen_s3;

	// stage 4: scalar force
	logic               v_s4;
	logic signed [47:0] frc_s4;
	logic [2:0][30:0]   um_s4;
	logic [2:0]         uneg_s4;
	logic               acc_s4, start_s4, degen_s4;

	logic signed [59:0] sfk_c, sfc_c;

	always_comb begin
		sfk_c = fkneg_s3 ? $signed({3'b000, fk_s3}) : -$signed({3'b000, fk_s3});
		sfc_c = spdneg_s3 ? $signed({3'b000, fcp_s3[64:8]}) : -$signed({3'b000, fcp_s3[64:8]});
	end

	// stage 5: force vector partial products
	logic             v_s5;
	logic [2:0][54:0] lo_s5, hi_s5;
	logic [2:0]       fneg_s5;
	logic             acc_s5, start_s5, degen_s5;

	logic [47:0] fm_c;

	assign fm_c = frc_s4[47] ? 48'(-frc_s4) : frc_s4;

	// stage 6: force vector
	logic                    v_s6;
	logic [2:0][48:0]        f_s6;
	logic                    acc_s6, start_s6, degen_s6;

	logic [2:0][78:0] tot_c;
	logic [2:0][48:0] m_c;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			tot_c[i] = {hi_s5[i], 24'd0} + {24'd0, lo_s5[i]};
			m_c[i]   = tot_c[i][78:30];
		end
	end

	// stage 7: accumulator and output register
	logic             v_s7;
	result_t          res_s7;
	logic [2:0][47:0] acc_q;
	logic [2:0][47:0] base_c, new_c;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			base_c[i] = start_s6 ? '0 : acc_q[i];
			if (acc_s6 && !degen_s6)
				new_c[i] = sat48(60'($signed(base_c[i])) - 60'($signed(f_s6[i])));
			else
				new_c[i] = base_c[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			acc_q <= '0;
		end else if (en) begin
			v_s1 <= in_v;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			if (v_s6)
				acc_q <= new_c;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s1     <= p_c;
			fkp_s1   <= {32'd0, smag_c} * {33'd0, in_side.kg};
			fkneg_s1 <= st_c[33];
			um_s1    <= in_q;
			uneg_s1  <= in_side.dneg;
			cg_s1    <= in_side.cg;
			acc_s1   <= in_side.acc_en;
			start_s1 <= in_side.start;
			degen_s1 <= in_side.degen;

			spd_s2    <= dabs_c[62:30];
			spdneg_s2 <= dot_c[63];
			fk_s2     <= fkp_s1[64:8];
			fkneg_s2  <= fkneg_s1;
			um_s2     <= um_s1;
			uneg_s2   <= uneg_s1;
			cg_s2     <= cg_s1;
			acc_s2    <= acc_s1;
			start_s2  <= start_s1;
			degen_s2  <= degen_s1;

			fcp_s3    <= {32'd0, spd_s2} * {33'd0, cg_s2};
			spdneg_s3 <= spdneg_s2;
			fk_s3     <= fk_s2;
			fkneg_s3  <= fkneg_s2;
			um_s3     <= um_s2;
			uneg_s3   <= uneg_s2;
			acc_s3    <= acc_s2;
			start_s3  <= start_s2;
			degen_s3  <= degen_s2;

			frc_s4   <= sat48(sfk_c + sfc_c);
			um_s4    <= um_s3;
			uneg_s4  <= uneg_s3;
			acc_s4   <= acc_s3;
			start_s4 <= start_s3;
			degen_s4 <= degen_s3;

			for (int i = 0; i < 3; i++) begin
				lo_s5[i]   <= {31'd0, fm_c[23:0]} * {24'd0, um_s4[i]};
				hi_s5[i]   <= {31'd0, fm_c[47:24]} * {24'd0, um_s4[i]};
				fneg_s5[i] <= frc_s4[47] ^ uneg_s4[i];
			end
			acc_s5   <= acc_s4;
			start_s5 <= start_s4;
			degen_s5 <= degen_s4;

			for (int i = 0; i < 3; i++)
				f_s6[i] <= fneg_s5[i] ? -m_c[i] : m_c[i];
			acc_s6   <= acc_s5;
			start_s6 <= start_s5;
			degen_s6 <= degen_s5;

			for (int i = 0; i < 3; i++)
				res_s7.force_v[i] <= degen_s6 ? '0 : f_s6[i][47:0];
			res_s7.wheel_v <= new_c;
			res_s7.degen   <= degen_s6;
		end
	end

	assign out_v   = v_s7;
	assign out_res = res_s7;

	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_v && out_res.degen |-> out_res.force_v == '0)
		else $error("degenerate item with nonzero force");

	a_acc_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!(en && v_s6) |=> acc_q == $past(acc_q))
		else $error("accumulator moved without an item");

	a_acc_skip: assert property (@(posedge clk) disable iff (!arst_n)
		en && v_s6 && !start_s6 && (degen_s6 || !acc_s6) |=> acc_q == $past(acc_q))
		else $error("accumulator changed by a mesh or degenerate item");

	a_out_wheel: assert property (@(posedge clk) disable iff (!arst_n)
		en && v_s6 |=> out_res.wheel_v == acc_q)
		else $error("wheel force output differs from accumulator");

endmodule
